[sv/hangul_two_set_composer_macros.svh]
// ---------------------------------------------------------------------------
// hangul two-set composer assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef HANGUL_TWO_SET_COMPOSER_MACROS_SVH
`define HANGUL_TWO_SET_COMPOSER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define HGL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define HGL_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HGL_ASSERT(label, prop, msg)
`define HGL_NEVER(label, cond, msg)
`endif

`endif

[sv/hgl_pkg.sv]
// ---------------------------------------------------------------------------
// hgl_pkg
// types, codes and jamo tables shared by the two-set hangul composer
// ---------------------------------------------------------------------------
`default_nettype none

package hgl_pkg;

    // raw action codes on the input channel
    localparam logic [2:0] ACT_CONSONANT = 3'd0;
    localparam logic [2:0] ACT_VOWEL     = 3'd1;
    localparam logic [2:0] ACT_OTHER     = 3'd2;
    localparam logic [2:0] ACT_BACKSPACE = 3'd3;
    localparam logic [2:0] ACT_FLUSH     = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_COMMIT  = 2'd0;
    localparam logic [1:0] KIND_DELETE  = 2'd1;
    localparam logic [1:0] KIND_PREEDIT = 2'd2;

    localparam logic [15:0] SYL_BASE = 16'hAC00;

    typedef enum logic [2:0] {
        CLS_CONS,
        CLS_VOWEL,
        CLS_OTHER,
        CLS_BACK,
        CLS_FLUSH,
        CLS_NONE
    } key_class_t;

    typedef enum logic [2:0] {
        LV_NONE,
        LV_INIT,
        LV_MED,
        LV_CMED,
        LV_FIN,
        LV_CFIN,
        LV_VOWEL
    } level_t;

    typedef struct packed {
        key_class_t  cls;
        logic [4:0]  jamo;
        logic [15:0] ch;
    } key_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cp;
        logic [23:0] word;
        logic [1:0]  len;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] first;
        logic [4:0] second;
    } split_t;

    function automatic logic [15:0] syllable(input logic [4:0] a, input logic [4:0] b,
                                             input logic [4:0] c);
        logic [15:0] s;
        s = SYL_BASE + 16'(a) * 16'd588 + 16'(b) * 16'd28 + 16'(c);
        return s;
    endfunction

    function automatic result_t make_result(input logic [1:0] kind, input logic [15:0] cp,
                                            input logic has, input logic last);
        result_t r;
        r.kind = kind;
        r.last = last;
        r.cp   = has ? cp : 16'h0000;
        if (!has)
        begin
            r.word = 24'h000000;
            r.len  = 2'd0;
        end
        else if (cp < 16'h0080)
        begin
            r.word = {16'h0000, cp[7:0]};
            r.len  = 2'd1;
        end
        else if (cp < 16'h0800)
        begin
            r.word = {8'h00, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            r.len  = 2'd2;
        end
        else
        begin
            r.word = {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            r.len  = 2'd3;
        end
        return r;
    endfunction

    // doubled initials never become finals
    function automatic logic final_ok(input logic [4:0] t);
        return !(t == 5'd1 || t == 5'd4 || t == 5'd8 || t == 5'd13);
    endfunction

    function automatic logic [4:0] init_to_final(input logic [4:0] t);
        logic [4:0] f;
        case (t)
            5'd0:    f = 5'd1;
            5'd1:    f = 5'd2;
            5'd2:    f = 5'd4;
            5'd3:    f = 5'd7;
            5'd5:    f = 5'd8;
            5'd6:    f = 5'd16;
            5'd7:    f = 5'd17;
            5'd9:    f = 5'd19;
            5'd10:   f = 5'd20;
            5'd11:   f = 5'd21;
            5'd12:   f = 5'd22;
            5'd14:   f = 5'd23;
            5'd15:   f = 5'd24;
            5'd16:   f = 5'd25;
            5'd17:   f = 5'd26;
            5'd18:   f = 5'd27;
            default: f = 5'd0;
        endcase
        return f;
    endfunction

    function automatic logic [4:0] final_to_init(input logic [4:0] f);
        logic [4:0] t;
        case (f)
            5'd2:    t = 5'd1;
            5'd4:    t = 5'd2;
            5'd7:    t = 5'd3;
            5'd8:    t = 5'd5;
            5'd16:   t = 5'd6;
            5'd17:   t = 5'd7;
            5'd19:   t = 5'd9;
            5'd20:   t = 5'd10;
            5'd21:   t = 5'd11;
            5'd22:   t = 5'd12;
            5'd23:   t = 5'd14;
            5'd24:   t = 5'd15;
            5'd25:   t = 5'd16;
            5'd26:   t = 5'd17;
            5'd27:   t = 5'd18;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    // compound final into first final and second half as an initial
    function automatic split_t split_final(input logic [4:0] f);
        split_t s;
        s.ok     = 1'b1;
        s.first  = 5'd8;
        s.second = 5'd0;
        case (f)
            5'd3:
            begin
                s.first  = 5'd1;
                s.second = 5'd9;
            end
            5'd5:
            begin
                s.first  = 5'd4;
                s.second = 5'd12;
            end
            5'd6:
            begin
                s.first  = 5'd4;
                s.second = 5'd18;
            end
            5'd9:    s.second = 5'd0;
            5'd10:   s.second = 5'd6;
            5'd11:   s.second = 5'd7;
            5'd12:   s.second = 5'd9;
            5'd13:   s.second = 5'd16;
            5'd14:   s.second = 5'd17;
            5'd15:   s.second = 5'd18;
            5'd18:
            begin
                s.first  = 5'd17;
                s.second = 5'd9;
            end
            default:
            begin
                s.ok    = 1'b0;
                s.first = 5'd0;
            end
        endcase
        return s;
    endfunction

    function automatic logic [4:0] join_final(input logic [4:0] c, input logic [4:0] t);
        logic [4:0] x;
        x = 5'd0;
        if (c == 5'd1 && t == 5'd9)
            x = 5'd3;
        else if (c == 5'd4 && t == 5'd12)
            x = 5'd5;
        else if (c == 5'd4 && t == 5'd18)
            x = 5'd6;
        else if (c == 5'd8)
        begin
            case (t)
                5'd0:    x = 5'd9;
                5'd6:    x = 5'd10;
                5'd7:    x = 5'd11;
                5'd9:    x = 5'd12;
                5'd16:   x = 5'd13;
                5'd17:   x = 5'd14;
                5'd18:   x = 5'd15;
                default: x = 5'd0;
            endcase
        end
        else if (c == 5'd17 && t == 5'd9)
            x = 5'd18;
        return x;
    endfunction

    function automatic logic [4:0] join_medial(input logic [4:0] b, input logic [4:0] t);
        logic [4:0] x;
        x = 5'd0;
        if (b == 5'd8 && t == 5'd0)
            x = 5'd9;
        else if (b == 5'd8 && t == 5'd1)
            x = 5'd10;
        else if (b == 5'd8 && t == 5'd20)
            x = 5'd11;
        else if (b == 5'd13 && t == 5'd4)
            x = 5'd14;
        else if (b == 5'd13 && t == 5'd5)
            x = 5'd15;
        else if (b == 5'd13 && t == 5'd20)
            x = 5'd16;
        else if (b == 5'd18 && t == 5'd20)
            x = 5'd19;
        return x;
    endfunction

endpackage

`default_nettype wire

[sv/hgl_front.sv]
// ---------------------------------------------------------------------------
// hgl_front
// input register stage: takes keystroke items and classifies the action
// ---------------------------------------------------------------------------
`default_nettype none

module hgl_front
    import hgl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [4:0]  jamo_index,
    input  wire logic [15:0] char_code,
    output logic             push_valid,
    input  wire logic        push_ready,
    output key_item_t        push_item
);

    logic      vld_reg;
    logic      vld_next;
    key_item_t item_reg;
    key_item_t item_next;
    logic      take;

    assign in_ready   = !vld_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = vld_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (push_ready)
            vld_next = 1'b0;
        if (take)
        begin
            vld_next       = 1'b1;
            item_next.jamo = jamo_index;
            item_next.ch   = char_code;
            case (action)
                ACT_CONSONANT: item_next.cls = CLS_CONS;
                ACT_VOWEL:     item_next.cls = CLS_VOWEL;
                ACT_OTHER:     item_next.cls = CLS_OTHER;
                ACT_BACKSPACE: item_next.cls = CLS_BACK;
                ACT_FLUSH:     item_next.cls = CLS_FLUSH;
                default:       item_next.cls = CLS_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

[sv/hgl_queue.sv]
// ---------------------------------------------------------------------------
// hgl_queue
// short item queue between the classifying front and the composing back
// ---------------------------------------------------------------------------
`default_nettype none

module hgl_queue
    import hgl_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire key_item_t        push_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output key_item_t             pop_item,
    output logic [CNT_W-1:0]      count
);

    key_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign count      = cnt_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[sv/hgl_back.sv]
// ---------------------------------------------------------------------------
// hgl_back
// composing automaton: updates the syllable state and drains up to three
// results per item through a shift buffer
// ---------------------------------------------------------------------------
`default_nettype none

module hgl_back
    import hgl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire key_item_t   pop_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      code_point,
    output logic [23:0]      utf8_word,
    output logic [1:0]       utf8_length,
    output logic             last_of_run
);

    level_t      lv_reg;
    level_t      lv_next;
    logic [4:0]  ini_reg;
    logic [4:0]  ini_next;
    logic [4:0]  med_reg;
    logic [4:0]  med_next;
    logic [4:0]  fin_reg;
    logic [4:0]  fin_next;
    logic [15:0] pre_reg;
    logic [15:0] pre_next;
    result_t     res_reg [3];
    result_t     res_next [3];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    logic        pop;
    logic        out_fire;
    result_t     pend [2];
    logic [1:0]  npend;
    result_t     preedit;
    logic        restart;
    logic [4:0]  jf;
    logic [4:0]  jm;
    split_t      sp;
    logic [4:0]  t;

    assign pop_ready   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign pop         = pop_valid && pop_ready;
    assign out_valid   = cnt_reg != 2'd0;
    assign out_fire    = out_valid && out_ready;
    assign kind        = res_reg[0].kind;
    assign code_point  = res_reg[0].cp;
    assign utf8_word   = res_reg[0].word;
    assign utf8_length = res_reg[0].len;
    assign last_of_run = res_reg[0].last;

    // automaton step for the item at the head of the queue
    always_comb
    begin
        lv_next  = lv_reg;
        ini_next = ini_reg;
        med_next = med_reg;
        fin_next = fin_reg;
        pre_next = pre_reg;
        pend[0]  = make_result(KIND_COMMIT, 16'h0000, 1'b0, 1'b0);
        pend[1]  = pend[0];
        npend    = 2'd0;
        restart  = 1'b0;
        t        = pop_item.jamo;
        jf       = join_final(fin_reg, t);
        jm       = join_medial(med_reg, t);
        sp       = split_final(fin_reg);

        case (pop_item.cls)
            CLS_CONS:
            begin
                if (lv_reg == LV_MED || lv_reg == LV_CMED)
                begin
                    if (final_ok(t))
                    begin
                        fin_next = init_to_final(t);
                        pre_next = syllable(ini_reg, med_reg, fin_next);
                        lv_next  = LV_FIN;
                    end
                    else
                        restart = 1'b1;
                end
                else if (lv_reg == LV_FIN && jf != 5'd0)
                begin
                    fin_next = jf;
                    pre_next = syllable(ini_reg, med_reg, jf);
                    lv_next  = LV_CFIN;
                end
                else
                    restart = 1'b1;
                if (restart)
                begin
                    if (lv_reg != LV_NONE)
                    begin
                        pend[0] = make_result(KIND_COMMIT, pre_reg, 1'b1, 1'b0);
                        npend   = 2'd1;
                    end
                    ini_next = t;
                    pre_next = pop_item.ch;
                    lv_next  = LV_INIT;
                end
            end
            CLS_VOWEL:
            begin
                if (lv_reg == LV_INIT)
                begin
                    med_next = t;
                    pre_next = syllable(ini_reg, t, 5'd0);
                    lv_next  = LV_MED;
                end
                else if (lv_reg == LV_MED && jm != 5'd0)
                begin
                    med_next = jm;
                    pre_next = syllable(ini_reg, jm, 5'd0);
                    lv_next  = LV_CMED;
                end
                else if (lv_reg == LV_FIN)
                begin
                    // final moves onto the new vowel as its initial
                    pend[0]  = make_result(KIND_COMMIT, syllable(ini_reg, med_reg, 5'd0),
                                           1'b1, 1'b0);
                    npend    = 2'd1;
                    ini_next = final_to_init(fin_reg);
                    med_next = t;
                    pre_next = syllable(ini_next, t, 5'd0);
                    lv_next  = LV_MED;
                end
                else if (lv_reg == LV_CFIN)
                begin
                    // compound final splits, second half opens the next syllable
                    if (sp.ok)
                        fin_next = sp.first;
                    ini_next = sp.ok ? sp.second : 5'd0;
                    pend[0]  = make_result(KIND_COMMIT, syllable(ini_reg, med_reg, fin_next),
                                           1'b1, 1'b0);
                    npend    = 2'd1;
                    med_next = t;
                    pre_next = syllable(ini_next, t, 5'd0);
                    lv_next  = LV_MED;
                end
                else
                begin
                    if (lv_reg != LV_NONE)
                    begin
                        pend[0] = make_result(KIND_COMMIT, pre_reg, 1'b1, 1'b0);
                        npend   = 2'd1;
                    end
                    med_next = t;
                    pre_next = pop_item.ch;
                    lv_next  = LV_VOWEL;
                end
            end
            CLS_OTHER:
            begin
                if (lv_reg != LV_NONE)
                begin
                    pend[0] = make_result(KIND_COMMIT, pre_reg, 1'b1, 1'b0);
                    pend[1] = make_result(KIND_COMMIT, pop_item.ch, 1'b1, 1'b0);
                    npend   = 2'd2;
                end
                else
                begin
                    pend[0] = make_result(KIND_COMMIT, pop_item.ch, 1'b1, 1'b0);
                    npend   = 2'd1;
                end
                pre_next = 16'h0000;
                lv_next  = LV_NONE;
            end
            CLS_BACK:
            begin
                // composing: the syllable is just dropped
                if (lv_reg == LV_NONE)
                begin
                    pend[0] = make_result(KIND_DELETE, 16'h0000, 1'b0, 1'b0);
                    npend   = 2'd1;
                end
                pre_next = 16'h0000;
                lv_next  = LV_NONE;
            end
            CLS_FLUSH:
            begin
                if (lv_reg != LV_NONE)
                begin
                    pend[0] = make_result(KIND_COMMIT, pre_reg, 1'b1, 1'b0);
                    npend   = 2'd1;
                end
                pre_next = 16'h0000;
                lv_next  = LV_NONE;
            end
            default:
            begin
                lv_next = lv_reg;
            end
        endcase

        preedit = make_result(KIND_PREEDIT, pre_next, lv_next != LV_NONE, 1'b1);
    end

    // result buffer: head is the output, shifts on each taken result
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (out_fire)
        begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
        if (pop)
        begin
            res_next[0] = (npend == 2'd0) ? preedit : pend[0];
            res_next[1] = (npend == 2'd1) ? preedit : pend[1];
            res_next[2] = preedit;
            cnt_next    = npend + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg  <= LV_NONE;
            ini_reg <= 5'd0;
            med_reg <= 5'd0;
            fin_reg <= 5'd0;
            pre_reg <= 16'h0000;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
            begin
                lv_reg  <= lv_next;
                ini_reg <= ini_next;
                med_reg <= med_next;
                fin_reg <= fin_next;
                pre_reg <= pre_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

[sv/hangul_two_set_composer.sv]
// ---------------------------------------------------------------------------
// hangul_two_set_composer
// two-set hangul keystroke composer with utf-8 encoded results
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid/in_ready    action, jamo_index, char_code
//  result   out_valid/out_ready  kind, code_point, utf8_word, utf8_length,
//                                last_of_run
//
//  an item produces 1 to 3 results, drained one at a time through the
//  single result slot at the head of the back end's three-entry buffer
//  the first result passes the front register, then the queue, then the
//  back buffer before it is valid; the next item is taken while results
//  still drain
//  reset clears the composition state at once, no clearing pass
//  either side may stall freely; the queue holds QUEUE_DEPTH items
// ---------------------------------------------------------------------------
`default_nettype none

`include "hangul_two_set_composer_macros.svh"

module hangul_two_set_composer
    import hgl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [4:0]  jamo_index,
    input  wire logic [15:0] char_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      code_point,
    output logic [23:0]      utf8_word,
    output logic [1:0]       utf8_length,
    output logic             last_of_run
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             push_valid;
    logic             push_ready;
    key_item_t        push_item;
    logic             pop_valid;
    logic             pop_ready;
    key_item_t        pop_item;
    logic [CNT_W-1:0] q_count;

    hgl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .jamo_index (jamo_index),
        .char_code  (char_code),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    hgl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .count      (q_count)
    );

    hgl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .code_point  (code_point),
        .utf8_word   (utf8_word),
        .utf8_length (utf8_length),
        .last_of_run (last_of_run)
    );

    // only the preedit update closes an item
    `HGL_ASSERT(a_last_is_preedit,
                (out_valid && last_of_run) |-> (kind == KIND_PREEDIT),
                "last result is not a preedit update")
    // empty encodings carry no character
    `HGL_ASSERT(a_empty_code,
                (out_valid && utf8_length == 2'd0) |->
                    (code_point == 16'h0000 && utf8_word == 24'h000000),
                "empty result carries a character")
    // delete commands carry no bytes
    `HGL_NEVER(a_delete_bytes,
               out_valid && kind == KIND_DELETE && utf8_length != 2'd0,
               "delete result carries bytes")
    // queue never holds more than its depth
    `HGL_NEVER(a_queue_over, q_count > CNT_W'(QUEUE_DEPTH), "item queue overfilled")

endmodule

`default_nettype wire

[sim/tb_hangul_two_set_composer.sv]
// ---------------------------------------------------------------------------
// tb_hangul_two_set_composer
// Self-checking testbench for the two-set hangul keystroke composer.
// A short table of directed keystrokes comes first. Rows that are easy to
// work out by hand (idle backspace, flush, utf-8 boundaries) carry their
// expected results in the table. Random keystroke streams follow, biased
// towards compound medials and finals. Every item is run through a local
// model of the automaton, and each result is compared field by field in
// order. Both handshakes idle at random, with one calm stretch and one
// full drain of the result channel.
// ---------------------------------------------------------------------------
module tb_hangul_two_set_composer
    import hgl_pkg::*;
();

    localparam int RANDOM_KEYS = 243;
    localparam result_t NO_PREEDIT = {KIND_PREEDIT, 16'h0000, 24'h000000, 2'd0, 1'b1};

    typedef struct packed {
        logic [2:0]  act;
        logic [4:0]  jamo;
        logic [15:0] ch;
        logic        typed;
        logic        has_first;
        result_t     first;
    } key_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  action = ACT_FLUSH;
    logic [4:0]  jamo_index = 5'd0;
    logic [15:0] char_code = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] code_point;
    logic [23:0] utf8_word;
    logic [1:0]  utf8_length;
    logic        last_of_run;

    // typed expectation that travels with the item on the input channel
    logic        row_typed = 1'b0;
    logic        row_has_first = 1'b0;
    result_t     row_first = '0;

    // local copy of the composition state
    level_t      lvl = LV_NONE;
    logic [4:0]  cur_init = 5'd0;
    logic [4:0]  cur_med = 5'd0;
    logic [4:0]  cur_fin = 5'd0;
    logic [15:0] pre_cp = 16'h0000;

    result_t     key_results[$];
    result_t     pending_results[$];
    key_row_t    directed_rows[$];

    bit          calm = 1'b0;
    int          fail_count = 0;
    int          keys_taken = 0;
    int          results_seen = 0;
    int          commits_seen = 0;
    int          deletes_seen = 0;
    logic [6:0]  levels_seen = '0;

    hangul_two_set_composer u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .jamo_index  (jamo_index),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .code_point  (code_point),
        .utf8_word   (utf8_word),
        .utf8_length (utf8_length),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // jamo tables
    // ------------------------------------------------------------------
    function automatic logic doubled_initial(input logic [4:0] t);
        case (t)
            5'd1, 5'd4, 5'd8, 5'd13: return 1'b1;
            default:                 return 1'b0;
        endcase
    endfunction

    function automatic logic [4:0] fin_of_init(input logic [4:0] t);
        case (t)
            5'd0:  return 5'd1;
            5'd1:  return 5'd2;
            5'd2:  return 5'd4;
            5'd3:  return 5'd7;
            5'd5:  return 5'd8;
            5'd6:  return 5'd16;
            5'd7:  return 5'd17;
            5'd9, 5'd10, 5'd11, 5'd12: return t + 5'd10;
            5'd14, 5'd15, 5'd16, 5'd17, 5'd18: return t + 5'd9;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] init_of_fin(input logic [4:0] f);
        case (f)
            5'd2:  return 5'd1;
            5'd4:  return 5'd2;
            5'd7:  return 5'd3;
            5'd8:  return 5'd5;
            5'd16: return 5'd6;
            5'd17: return 5'd7;
            5'd19, 5'd20, 5'd21, 5'd22: return f - 5'd10;
            5'd23, 5'd24, 5'd25, 5'd26, 5'd27: return f - 5'd9;
            default: return 5'd0;
        endcase
    endfunction

    // {is compound, first final, second half as an initial}
    function automatic logic [10:0] fin_split(input logic [4:0] f);
        case (f)
            5'd3:  return {1'b1, 5'd1, 5'd9};
            5'd5:  return {1'b1, 5'd4, 5'd12};
            5'd6:  return {1'b1, 5'd4, 5'd18};
            5'd9:  return {1'b1, 5'd8, 5'd0};
            5'd10: return {1'b1, 5'd8, 5'd6};
            5'd11: return {1'b1, 5'd8, 5'd7};
            5'd12: return {1'b1, 5'd8, 5'd9};
            5'd13: return {1'b1, 5'd8, 5'd16};
            5'd14: return {1'b1, 5'd8, 5'd17};
            5'd15: return {1'b1, 5'd8, 5'd18};
            5'd18: return {1'b1, 5'd17, 5'd9};
            default: return {1'b0, 5'd0, 5'd0};
        endcase
    endfunction

    function automatic logic [4:0] fin_pair(input logic [4:0] c, input logic [4:0] t);
        case ({c, t})
            {5'd1, 5'd9}:   return 5'd3;
            {5'd4, 5'd12}:  return 5'd5;
            {5'd4, 5'd18}:  return 5'd6;
            {5'd8, 5'd0}:   return 5'd9;
            {5'd8, 5'd6}:   return 5'd10;
            {5'd8, 5'd7}:   return 5'd11;
            {5'd8, 5'd9}:   return 5'd12;
            {5'd8, 5'd16}:  return 5'd13;
            {5'd8, 5'd17}:  return 5'd14;
            {5'd8, 5'd18}:  return 5'd15;
            {5'd17, 5'd9}:  return 5'd18;
            default:        return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] med_pair(input logic [4:0] b, input logic [4:0] t);
        case ({b, t})
            {5'd8, 5'd0}:   return 5'd9;
            {5'd8, 5'd1}:   return 5'd10;
            {5'd8, 5'd20}:  return 5'd11;
            {5'd13, 5'd4}:  return 5'd14;
            {5'd13, 5'd5}:  return 5'd15;
            {5'd13, 5'd20}: return 5'd16;
            {5'd18, 5'd20}: return 5'd19;
            default:        return 5'd0;
        endcase
    endfunction

    function automatic logic [15:0] syl_code(input logic [4:0] a, input logic [4:0] b,
                                             input logic [4:0] c);
        int unsigned s;
        s = 32'hAC00 + 588 * a + 28 * b + c;
        return s[15:0];
    endfunction

    // ------------------------------------------------------------------
    // composing automaton
    // ------------------------------------------------------------------
    task automatic add_result(input logic [1:0] k, input logic [15:0] cp, input logic has,
                              input logic last);
        result_t     r;
        logic [23:0] w;
        w = {8'h00, cp};
        r.kind = k;
        r.last = last;
        r.cp   = has ? cp : 16'h0000;
        if (!has)
        begin
            r.word = 24'h000000;
            r.len  = 2'd0;
        end
        else if (w < 24'h80)
        begin
            r.word = w;
            r.len  = 2'd1;
        end
        else if (w < 24'h800)
        begin
            r.word = ((24'hC0 | (w >> 6)) << 8) | (24'h80 | (w & 24'h3F));
            r.len  = 2'd2;
        end
        else
        begin
            r.word = ((24'hE0 | (w >> 12)) << 16) | ((24'h80 | ((w >> 6) & 24'h3F)) << 8)
                   | (24'h80 | (w & 24'h3F));
            r.len  = 2'd3;
        end
        key_results.insert(key_results.size(), r);
    endtask

    task automatic compose_key(input logic [2:0] act, input logic [4:0] t,
                               input logic [15:0] ch);
        level_t     was;
        logic [4:0] x;
        logic [4:0] second;
        logic [10:0] sp;
        bit         restart;
        key_results.delete();
        was = lvl;
        case (act)
            ACT_CONSONANT:
            begin
                restart = 1'b1;
                if ((was == LV_MED || was == LV_CMED) && !doubled_initial(t))
                begin
                    cur_fin = fin_of_init(t);
                    pre_cp  = syl_code(cur_init, cur_med, cur_fin);
                    lvl     = LV_FIN;
                    restart = 1'b0;
                end
                else if (was == LV_FIN && fin_pair(cur_fin, t) != 5'd0)
                begin
                    cur_fin = fin_pair(cur_fin, t);
                    pre_cp  = syl_code(cur_init, cur_med, cur_fin);
                    lvl     = LV_CFIN;
                    restart = 1'b0;
                end
                if (restart)
                begin
                    if (was != LV_NONE)
                        add_result(KIND_COMMIT, pre_cp, 1'b1, 1'b0);
                    cur_init = t;
                    pre_cp   = ch;
                    lvl      = LV_INIT;
                end
            end
            ACT_VOWEL:
            begin
                x = med_pair(cur_med, t);
                if (was == LV_INIT)
                begin
                    cur_med = t;
                    pre_cp  = syl_code(cur_init, t, 5'd0);
                    lvl     = LV_MED;
                end
                else if (was == LV_MED && x != 5'd0)
                begin
                    cur_med = x;
                    pre_cp  = syl_code(cur_init, x, 5'd0);
                    lvl     = LV_CMED;
                end
                else if (was == LV_FIN)
                begin
                    // the final moves onto the new vowel
                    add_result(KIND_COMMIT, syl_code(cur_init, cur_med, 5'd0), 1'b1, 1'b0);
                    cur_init = init_of_fin(cur_fin);
                    cur_med  = t;
                    pre_cp   = syl_code(cur_init, t, 5'd0);
                    lvl      = LV_MED;
                end
                else if (was == LV_CFIN)
                begin
                    sp     = fin_split(cur_fin);
                    second = 5'd0;
                    if (sp[10])
                    begin
                        second  = sp[4:0];
                        cur_fin = sp[9:5];
                    end
                    add_result(KIND_COMMIT, syl_code(cur_init, cur_med, cur_fin), 1'b1, 1'b0);
                    cur_init = second;
                    cur_med  = t;
                    pre_cp   = syl_code(second, t, 5'd0);
                    lvl      = LV_MED;
                end
                else
                begin
                    if (was != LV_NONE)
                        add_result(KIND_COMMIT, pre_cp, 1'b1, 1'b0);
                    cur_med = t;
                    pre_cp  = ch;
                    lvl     = LV_VOWEL;
                end
            end
            ACT_OTHER:
            begin
                if (was != LV_NONE)
                    add_result(KIND_COMMIT, pre_cp, 1'b1, 1'b0);
                add_result(KIND_COMMIT, ch, 1'b1, 1'b0);
                pre_cp = 16'h0000;
                lvl    = LV_NONE;
            end
            ACT_BACKSPACE:
            begin
                // while composing the syllable is simply dropped
                if (was == LV_NONE)
                    add_result(KIND_DELETE, 16'h0000, 1'b0, 1'b0);
                pre_cp = 16'h0000;
                lvl    = LV_NONE;
            end
            ACT_FLUSH:
            begin
                if (was != LV_NONE)
                    add_result(KIND_COMMIT, pre_cp, 1'b1, 1'b0);
                pre_cp = 16'h0000;
                lvl    = LV_NONE;
            end
            default:
            begin
            end
        endcase
        levels_seen[lvl] = 1'b1;
        add_result(KIND_PREEDIT, pre_cp, lvl != LV_NONE, 1'b1);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        results_seen++;
        if (got.kind == KIND_COMMIT)
            commits_seen++;
        if (got.kind == KIND_DELETE)
            deletes_seen++;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d arrived with nothing expected: kind %0d cp %h",
                         results_seen, got.kind, got.cp);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.cp !== want.cp || got.word !== want.word ||
                got.len !== want.len || got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d: expected kind %0d cp %h utf8 %h/%0d last %0d, %s",
                             results_seen, want.kind, want.cp, want.word, want.len, want.last,
                             $sformatf("got kind %0d cp %h utf8 %h/%0d last %0d",
                                       got.kind, got.cp, got.word, got.len, got.last));
            end
        end
    endtask

    // items are predicted as they are taken, results checked as they leave
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                keys_taken++;
                compose_key(action, jamo_index, char_code);
                if (row_typed)
                begin
                    if (row_has_first)
                        pending_results.insert(pending_results.size(), row_first);
                    pending_results.insert(pending_results.size(), NO_PREEDIT);
                end
                else
                begin
                    foreach (key_results[i])
                        pending_results.insert(pending_results.size(), key_results[i]);
                end
            end
            if (out_valid && out_ready)
                check_result({kind, code_point, utf8_word, utf8_length, last_of_run});
        end
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 24);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_key(input logic [2:0] act, input logic [4:0] jamo,
                            input logic [15:0] ch, input logic typed,
                            input logic has_first, input result_t first);
        if (!calm)
        begin
            while ($urandom_range(99) < 24)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        action        <= act;
        jamo_index    <= jamo;
        char_code     <= ch;
        row_typed     <= typed;
        row_has_first <= has_first;
        row_first     <= first;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic add_row(input logic [2:0] act, input logic [4:0] jamo,
                           input logic [15:0] ch);
        directed_rows.insert(directed_rows.size(), {act, jamo, ch, 1'b0, 1'b0, 45'd0});
    endtask

    task automatic add_typed_row(input logic [2:0] act, input logic [4:0] jamo,
                                 input logic [15:0] ch, input logic has_first,
                                 input result_t first);
        directed_rows.insert(directed_rows.size(), {act, jamo, ch, 1'b1, has_first, first});
    endtask

    function automatic logic [4:0] biased_consonant();
        case ($urandom_range(13))
            0:       return 5'd0;
            1:       return 5'd9;
            2:       return 5'd4;
            3:       return 5'd12;
            4:       return 5'd18;
            5:       return 5'd8;
            6:       return 5'd6;
            7:       return 5'd7;
            8:       return 5'd16;
            9:       return 5'd17;
            10:      return 5'd1;
            11:      return 5'd13;
            12:      return 5'd5;
            default: return 5'd3;
        endcase
    endfunction

    function automatic logic [4:0] biased_vowel();
        case ($urandom_range(7))
            0:       return 5'd8;
            1:       return 5'd0;
            2:       return 5'd1;
            3:       return 5'd20;
            4:       return 5'd13;
            5:       return 5'd4;
            6:       return 5'd5;
            default: return 5'd18;
        endcase
    endfunction

    initial
    begin : stimulus
        key_row_t    r;
        int          pick;
        logic [2:0]  k_act;
        logic [4:0]  k_jamo;
        logic [15:0] k_ch;

        // idle extremes and utf-8 length boundaries
        add_typed_row(ACT_BACKSPACE, 5'd0, 16'h0000, 1'b1,
                      {KIND_DELETE, 16'h0000, 24'h000000, 2'd0, 1'b0});
        add_typed_row(ACT_FLUSH, 5'd31, 16'hFFFF, 1'b0, '0);
        add_typed_row(ACT_OTHER, 5'd0, 16'h0000, 1'b1,
                      {KIND_COMMIT, 16'h0000, 24'h000000, 2'd1, 1'b0});
        add_typed_row(ACT_OTHER, 5'd0, 16'h0080, 1'b1,
                      {KIND_COMMIT, 16'h0080, 24'h00C280, 2'd2, 1'b0});
        add_typed_row(ACT_OTHER, 5'd0, 16'h0800, 1'b1,
                      {KIND_COMMIT, 16'h0800, 24'hE0A080, 2'd3, 1'b0});
        add_typed_row(ACT_OTHER, 5'd31, 16'hFFFF, 1'b1,
                      {KIND_COMMIT, 16'hFFFF, 24'hEFBFBF, 2'd3, 1'b0});
        add_typed_row(3'd7, 5'd31, 16'hFFFF, 1'b0, '0);
        // final, compound final, split onto a vowel
        add_row(ACT_CONSONANT, 5'd0, 16'h3131);
        add_row(ACT_VOWEL, 5'd0, 16'h314F);
        add_row(ACT_CONSONANT, 5'd0, 16'h3131);
        add_row(ACT_CONSONANT, 5'd9, 16'h3145);
        add_row(ACT_VOWEL, 5'd0, 16'h314F);
        // doubled initial, compound medial and compound final
        add_row(ACT_CONSONANT, 5'd8, 16'h3143);
        add_row(ACT_VOWEL, 5'd8, 16'h3157);
        add_row(ACT_VOWEL, 5'd0, 16'h314F);
        add_row(ACT_CONSONANT, 5'd5, 16'h3139);
        add_row(ACT_CONSONANT, 5'd16, 16'h314D);
        add_row(ACT_CONSONANT, 5'd18, 16'h314E);
        add_row(ACT_BACKSPACE, 5'd0, 16'h0000);
        // standalone vowels
        add_row(ACT_VOWEL, 5'd20, 16'h3163);
        add_row(ACT_VOWEL, 5'd13, 16'h315C);
        // out-of-range indices
        add_row(ACT_CONSONANT, 5'd31, 16'hFFFF);
        add_row(ACT_VOWEL, 5'd31, 16'h0000);
        add_row(ACT_CONSONANT, 5'd19, 16'h1234);
        add_row(ACT_VOWEL, 5'd1, 16'h3150);
        add_row(3'd5, 5'd3, 16'h0041);
        add_row(ACT_FLUSH, 5'd0, 16'h0000);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_key(r.act, r.jamo, r.ch, r.typed, r.has_first, r.first);
        end

        for (int n = 0; n < RANDOM_KEYS; n++)
        begin
            calm = (n >= 90 && n < 150);
            if (n == 200)
            begin
                // hold the input back until every result has drained
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            pick = $urandom_range(99);
            if (pick < 42)
                k_act = ACT_CONSONANT;
            else if (pick < 78)
                k_act = ACT_VOWEL;
            else if (pick < 83)
                k_act = ACT_OTHER;
            else if (pick < 88)
                k_act = ACT_BACKSPACE;
            else if (pick < 94)
                k_act = ACT_FLUSH;
            else
                k_act = 3'($urandom_range(7, 5));

            if ($urandom_range(99) < 8)
                k_jamo = 5'($urandom_range(31));
            else if (k_act == ACT_CONSONANT)
                k_jamo = $urandom_range(1) ? biased_consonant() : 5'($urandom_range(18));
            else
                k_jamo = $urandom_range(1) ? biased_vowel() : 5'($urandom_range(20));

            if (k_act == ACT_OTHER)
            begin
                case ($urandom_range(2))
                    0:       k_ch = 16'($urandom_range(16'h007F));
                    1:       k_ch = 16'($urandom_range(16'h07FF));
                    default: k_ch = 16'($urandom_range(16'hFFFF));
                endcase
            end
            else if ($urandom_range(99) < 25)
                k_ch = 16'($urandom_range(16'hFFFF));
            else
                k_ch = (k_act == ACT_VOWEL ? 16'h314F : 16'h3131) + 16'(k_jamo);

            send_key(k_act, k_jamo, k_ch, 1'b0, 1'b0, '0);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_results.size() != 0);
        // keep the clock running to catch any stray result
        repeat (12) @(posedge clk);

        $display("%0d keystrokes taken, %0d results checked (%0d commits, %0d deletes)",
                 keys_taken, results_seen, commits_seen, deletes_seen);
        $display("composition levels reached (bit per level): %b, failures: %0d",
                 levels_seen, fail_count);
        if (fail_count == 0)
            $display("hangul_two_set_composer: match");
        else
            $display("hangul_two_set_composer: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timed out with %0d results still expected", pending_results.size());
        $display("hangul_two_set_composer: mismatch");
        $finish;
    end

endmodule
